>>> sv/assert_macros.svh
// Assertion helpers shared by the receiver modules.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg
// Request codes, status codes, decoded operation types and the CRC-16 update
// shared by the image transfer receiver.
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam logic [2:0] REQ_BEGIN  = 3'd0;
  localparam logic [2:0] REQ_CHUNK  = 3'd1;
  localparam logic [2:0] REQ_DATA   = 3'd2;
  localparam logic [2:0] REQ_COMMIT = 3'd3;
  localparam logic [2:0] REQ_ABORT  = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE    = 3'd1;
  localparam logic [2:0] ST_NOT_STAGED   = 3'd2;
  localparam logic [2:0] ST_BAD_OFFSET   = 3'd3;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [31:0] MAX_IMAGE_RESET = 32'd1024 * 32'd1024;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BEGIN,
    OP_CHUNK,
    OP_DATA,
    OP_COMMIT,
    OP_ABORT
  } op_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_RECV   = 3'b010,
    MODE_STAGED = 3'b100
  } mode_t;

  typedef struct packed {
    op_t  op;
    logic size_bad;
    logic len_zero;
  } req_class_t;

  // CCITT-FALSE byte update, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/itr_if.sv
// ----------------------------------------------------------------------------
// itr_if
// Request and response channels of the image transfer receiver.
// ----------------------------------------------------------------------------
interface itr_req_if #(parameter int SIZE_BITS = 24) ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           req_type;
  logic [SIZE_BITS-1:0] image_bytes;
  logic [15:0]          image_crc;
  logic [SIZE_BITS-1:0] chunk_offset;
  logic [15:0]          chunk_length;
  logic [7:0]           data_byte;

  modport source (
    output valid, req_type, image_bytes, image_crc, chunk_offset, chunk_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, image_bytes, image_crc, chunk_offset, chunk_length, data_byte,
    output ready
  );
endinterface

interface itr_rsp_if #(parameter int SIZE_BITS = 24) ();
  logic                 valid;
  logic                 ready;
  logic                 status_valid;
  logic [2:0]           status_code;
  logic                 store_valid;
  logic [SIZE_BITS-1:0] store_address;
  logic [7:0]           store_byte;
  logic                 image_staged;

  modport source (
    output valid, status_valid, status_code, store_valid, store_address, store_byte,
           image_staged,
    input  ready
  );
  modport sink (
    input  valid, status_valid, status_code, store_valid, store_address, store_byte,
           image_staged,
    output ready
  );
endinterface

>>> sv/itr_front.sv
// ----------------------------------------------------------------------------
// itr_front
// Accepts requests, holds the size limit register and classifies each
// request (operation, size check, chunk end offset) for the queue.
// ----------------------------------------------------------------------------
module itr_front import itr_pkg::*; #(
  parameter int SIZE_BITS = 24,
  parameter int SUM_BITS  = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [SIZE_BITS-1:0] cfg_wdata,
  itr_req_if.sink              req,
  output logic                 push_valid,
  input  logic                 push_ready,
  output req_class_t           cls,
  output logic [SIZE_BITS-1:0] size,
  output logic [15:0]          crc_in,
  output logic [SIZE_BITS-1:0] off,
  output logic [SUM_BITS-1:0]  end_off,
  output logic [15:0]          len,
  output logic [7:0]           data
);

  logic [SIZE_BITS-1:0] max_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= SIZE_BITS'(MAX_IMAGE_RESET);
    end else if (cfg_we) begin
      max_bytes <= cfg_wdata;
    end
  end

  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  always_comb begin
    case (req.req_type)
      REQ_BEGIN:  cls.op = OP_BEGIN;
      REQ_CHUNK:  cls.op = OP_CHUNK;
      REQ_DATA:   cls.op = OP_DATA;
      REQ_COMMIT: cls.op = OP_COMMIT;
      REQ_ABORT:  cls.op = OP_ABORT;
      default:    cls.op = OP_NONE;
    endcase
    cls.size_bad = (req.image_bytes == '0) || (req.image_bytes > max_bytes);
    cls.len_zero = (req.chunk_length == 16'd0);
  end

  assign size    = req.image_bytes;
  assign crc_in  = req.image_crc;
  assign off     = req.chunk_offset;
  assign end_off = SUM_BITS'(req.chunk_offset) + SUM_BITS'(req.chunk_length);
  assign len     = req.chunk_length;
  assign data    = req.data_byte;

endmodule

>>> sv/itr_queue.sv
// ----------------------------------------------------------------------------
// itr_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module itr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
`include "assert_macros.svh"

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, count <= 2'd2)
  `ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + 2'd1)

endmodule

>>> sv/itr_back.sv
// ----------------------------------------------------------------------------
// itr_back
// Executes classified requests against the transfer state, runs the CRC
// and registers one response per request.
// ----------------------------------------------------------------------------
module itr_back import itr_pkg::*; #(
  parameter int SIZE_BITS = 24,
  parameter int SUM_BITS  = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  req_class_t           cls,
  input  logic [SIZE_BITS-1:0] size,
  input  logic [15:0]          crc_in,
  input  logic [SIZE_BITS-1:0] off,
  input  logic [SUM_BITS-1:0]  end_off,
  input  logic [15:0]          len,
  input  logic [7:0]           data,
  itr_rsp_if.source            rsp
);
`include "assert_macros.svh"

  mode_t                mode, mode_next;
  logic [SIZE_BITS-1:0] exp_size, exp_size_next;
  logic [15:0]          exp_crc, exp_crc_next;
  logic [SIZE_BITS-1:0] rcvd, rcvd_next;
  logic [15:0]          crc, crc_next;
  logic [15:0]          left, left_next;

  logic                 out_valid;
  logic                 sv, sv_next;
  logic [2:0]           code, code_next;
  logic                 wv, wv_next;
  logic [SIZE_BITS-1:0] waddr, waddr_next;
  logic [7:0]           wbyte, wbyte_next;
  logic                 staged;

  logic                 fire;

  assign fire    = q_valid && (!out_valid || rsp.ready);
  assign q_ready = fire;

  always_comb begin
    mode_next     = mode;
    exp_size_next = exp_size;
    exp_crc_next  = exp_crc;
    rcvd_next     = rcvd;
    crc_next      = crc;
    left_next     = left;
    sv_next       = 1'b0;
    code_next     = ST_OK;
    wv_next       = 1'b0;
    waddr_next    = '0;
    wbyte_next    = 8'd0;
    case (cls.op)
      OP_BEGIN: begin
        sv_next = 1'b1;
        if (mode == MODE_RECV) begin
          mode_next = MODE_IDLE;
          rcvd_next = '0;
          left_next = 16'd0;
        end
        if (cls.size_bad) begin
          code_next = ST_TOO_LARGE;
        end else begin
          exp_size_next = size;
          exp_crc_next  = crc_in;
          rcvd_next     = '0;
          crc_next      = CRC_INIT;
          left_next     = 16'd0;
          mode_next     = MODE_RECV;
        end
      end
      OP_CHUNK: begin
        sv_next = 1'b1;
        if (mode != MODE_RECV) begin
          code_next = ST_NOT_STAGED;
        end else begin
          left_next = 16'd0;
          if (off < rcvd) begin
            code_next = ST_OK;
          end else if (off > rcvd) begin
            code_next = ST_BAD_OFFSET;
          end else if (cls.len_zero || (end_off > SUM_BITS'(exp_size))) begin
            code_next = ST_BAD_OFFSET;
          end else begin
            left_next = len;
          end
        end
      end
      OP_DATA: begin
        if ((mode == MODE_RECV) && (left != 16'd0)) begin
          wv_next    = 1'b1;
          waddr_next = rcvd;
          wbyte_next = data;
          crc_next   = crc_feed(crc, data);
          rcvd_next  = rcvd + SIZE_BITS'(1);
          left_next  = left - 16'd1;
        end
      end
      OP_COMMIT: begin
        sv_next = 1'b1;
        if ((mode != MODE_RECV) || (rcvd != exp_size)) begin
          code_next = ST_NOT_STAGED;
        end else if (crc != exp_crc) begin
          code_next     = ST_CRC_MISMATCH;
          mode_next     = MODE_IDLE;
          exp_size_next = '0;
          exp_crc_next  = 16'd0;
          rcvd_next     = '0;
          crc_next      = CRC_INIT;
          left_next     = 16'd0;
        end else begin
          left_next = 16'd0;
          mode_next = MODE_STAGED;
        end
      end
      OP_ABORT: begin
        sv_next       = 1'b1;
        mode_next     = MODE_IDLE;
        exp_size_next = '0;
        exp_crc_next  = 16'd0;
        rcvd_next     = '0;
        crc_next      = CRC_INIT;
        left_next     = 16'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      exp_size  <= '0;
      exp_crc   <= 16'd0;
      rcvd      <= '0;
      crc       <= CRC_INIT;
      left      <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        mode     <= mode_next;
        exp_size <= exp_size_next;
        exp_crc  <= exp_crc_next;
        rcvd     <= rcvd_next;
        crc      <= crc_next;
        left     <= left_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sv     <= sv_next;
      code   <= code_next;
      wv     <= wv_next;
      waddr  <= waddr_next;
      wbyte  <= wbyte_next;
      staged <= (mode_next == MODE_STAGED);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status_valid  = sv;
  assign rsp.status_code   = code;
  assign rsp.store_valid   = wv;
  assign rsp.store_address = waddr;
  assign rsp.store_byte    = wbyte;
  assign rsp.image_staged  = staged;

  // admitted bytes never run past the announced size
  `ASSERT_IMPLIES(a_window, clk, rst, mode == MODE_RECV,
    SUM_BITS'(rcvd) + SUM_BITS'(left) <= SUM_BITS'(exp_size))
  `ASSERT_NEXT(a_fire_shows, clk, rst, fire, rsp.valid)
  `ASSERT_IMPLIES(a_one_kind, clk, rst, rsp.valid, !(rsp.status_valid && rsp.store_valid))

endmodule

>>> sv/image_transfer_receiver_crc16_unit.sv
// ----------------------------------------------------------------------------
// image_transfer_receiver_crc16_unit
// Update image receiver: begin, chunk header, data byte, commit and abort
// requests; issues store writes and verifies a CRC-16 on commit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per valid/ready handshake; rsp returns exactly
//   one response per request, in order. A response holds either a status
//   (begin, chunk header, commit, abort), a store write (admitted data
//   byte), or neither (stray byte, unknown request), plus image_staged.
//   cfg_we/cfg_wdata write the size limit; write only while idle.
// Path: an accepted request is written into the queue, and the queue head is
//   executed straight into the response register.
// Throughput: one request per cycle while rsp.ready stays high; the back end
//   executes one request per cycle, each with a single unrolled CRC byte update.
// Stall: a two-entry queue sits between the classifying front and the
//   executing back; the response register holds while rsp.ready is low and
//   req.ready drops once the queue is full.
// Reset: synchronous; transfer state returns to idle, CRC to 0xFFFF and the
//   size limit to 1 MiB. No clearing pass is needed.
// ----------------------------------------------------------------------------
module image_transfer_receiver_crc16_unit import itr_pkg::*; #(
  parameter int SIZE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [SIZE_BITS-1:0] cfg_wdata,
  itr_req_if.sink              req,
  itr_rsp_if.source            rsp
);

  localparam int SUM_BITS = ((SIZE_BITS > 16) ? SIZE_BITS : 16) + 1;
  localparam int Q_WIDTH  = $bits(req_class_t) + SIZE_BITS + 16 + SIZE_BITS + SUM_BITS + 16 + 8;

  logic                 push_valid;
  logic                 push_ready;
  req_class_t           f_cls;
  logic [SIZE_BITS-1:0] f_size;
  logic [15:0]          f_crc;
  logic [SIZE_BITS-1:0] f_off;
  logic [SUM_BITS-1:0]  f_end;
  logic [15:0]          f_len;
  logic [7:0]           f_data;

  logic                 q_valid;
  logic                 q_ready;
  logic [Q_WIDTH-1:0]   q_in;
  logic [Q_WIDTH-1:0]   q_out;

  req_class_t           b_cls;
  logic [SIZE_BITS-1:0] b_size;
  logic [15:0]          b_crc;
  logic [SIZE_BITS-1:0] b_off;
  logic [SUM_BITS-1:0]  b_end;
  logic [15:0]          b_len;
  logic [7:0]           b_data;

  itr_front #(
    .SIZE_BITS (SIZE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .cls        (f_cls),
    .size       (f_size),
    .crc_in     (f_crc),
    .off        (f_off),
    .end_off    (f_end),
    .len        (f_len),
    .data       (f_data)
  );

  assign q_in = {f_cls, f_size, f_crc, f_off, f_end, f_len, f_data};

  itr_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (q_in),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_out)
  );

  assign {b_cls, b_size, b_crc, b_off, b_end, b_len, b_data} = q_out;

  itr_back #(
    .SIZE_BITS (SIZE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .cls     (b_cls),
    .size    (b_size),
    .crc_in  (b_crc),
    .off     (b_off),
    .end_off (b_end),
    .len     (b_len),
    .data    (b_data),
    .rsp     (rsp)
  );

endmodule

>>> bench/itr_tb_pkg.sv
// ----------------------------------------------------------------------------
// itr_tb_pkg
// Bench-side types for the image receiver testbench: the response record the
// checker compares, the reserved request codes, and a bitwise CRC-16 used to
// build images and to predict the receiver's running check.
// ----------------------------------------------------------------------------
package itr_tb_pkg;
  import itr_pkg::*;

  localparam int SIZE_W = 24;

  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic              status_valid;
    logic [2:0]        status_code;
    logic              store_valid;
    logic [SIZE_W-1:0] store_address;
    logic [7:0]        store_byte;
    logic              image_staged;
  } rsp_item_t;

  // one bit per step, feedback from msb xor the incoming bit
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ d[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

endpackage

>>> bench/itr_checker.sv
// ----------------------------------------------------------------------------
// itr_checker
// Watches the request, response and limit-write ports of the image receiver,
// predicts each response from its own copy of the transfer state and
// compares every returned response, in order, field by field.
// ----------------------------------------------------------------------------
module itr_checker import itr_pkg::*, itr_tb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  itr_req_if                req,
  itr_rsp_if                rsp,
  output int unsigned       errors,
  output int unsigned       pending
);

  logic [SIZE_W-1:0] size_limit;
  mode_t             mode;
  logic [SIZE_W-1:0] want_size;
  logic [15:0]       want_crc;
  logic [SIZE_W-1:0] got_bytes;
  logic [15:0]       crc_acc;
  logic [15:0]       owed;
  rsp_item_t         expected_q[$];

  function automatic void drop_transfer();
    mode      = MODE_IDLE;
    want_size = '0;
    want_crc  = '0;
    got_bytes = '0;
    crc_acc   = CRC_INIT;
    owed      = '0;
  endfunction

  function automatic rsp_item_t apply_request(input logic [2:0] kind,
                                              input logic [SIZE_W-1:0] size,
                                              input logic [15:0] crc,
                                              input logic [SIZE_W-1:0] off,
                                              input logic [15:0] len,
                                              input logic [7:0] b);
    rsp_item_t r;
    r = '0;
    case (kind)
      REQ_BEGIN: begin
        r.status_valid = 1'b1;
        if (mode == MODE_RECV) begin
          mode      = MODE_IDLE;
          got_bytes = '0;
          owed      = '0;
        end
        if (size == '0 || size > size_limit) begin
          r.status_code = ST_TOO_LARGE;
        end else begin
          want_size = size;
          want_crc  = crc;
          got_bytes = '0;
          crc_acc   = CRC_INIT;
          owed      = '0;
          mode      = MODE_RECV;
        end
      end
      REQ_CHUNK: begin
        r.status_valid = 1'b1;
        if (mode != MODE_RECV) begin
          r.status_code = ST_NOT_STAGED;
        end else begin
          owed = '0;
          if (off < got_bytes) begin
            r.status_code = ST_OK;
          end else if (off > got_bytes) begin
            r.status_code = ST_BAD_OFFSET;
          end else if (len == '0 ||
                       ({1'b0, off} + {{(SIZE_W-15){1'b0}}, len}) > {1'b0, want_size}) begin
            r.status_code = ST_BAD_OFFSET;
          end else begin
            owed = len;
          end
        end
      end
      REQ_DATA: begin
        if (mode == MODE_RECV && owed != '0) begin
          r.store_valid   = 1'b1;
          r.store_address = got_bytes;
          r.store_byte    = b;
          crc_acc         = crc16_step(crc_acc, b);
          got_bytes       = got_bytes + 1'b1;
          owed            = owed - 1'b1;
        end
      end
      REQ_COMMIT: begin
        r.status_valid = 1'b1;
        if (mode != MODE_RECV || got_bytes != want_size) begin
          r.status_code = ST_NOT_STAGED;
        end else if (crc_acc != want_crc) begin
          drop_transfer();
          r.status_code = ST_CRC_MISMATCH;
        end else begin
          owed = '0;
          mode = MODE_STAGED;
        end
      end
      REQ_ABORT: begin
        r.status_valid = 1'b1;
        drop_transfer();
      end
      default: begin
      end
    endcase
    r.image_staged = (mode == MODE_STAGED);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_item_t seen;
    rsp_item_t want;
    if (rst) begin
      errors     = 0;
      size_limit = SIZE_W'(MAX_IMAGE_RESET);
      drop_transfer();
      expected_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen = {rsp.status_valid, rsp.status_code, rsp.store_valid, rsp.store_address,
                rsp.store_byte, rsp.image_staged};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none actual %0h", $time, seen);
        end else begin
          want = expected_q.pop_front();
          check_field("status_valid", 32'(want.status_valid), 32'(seen.status_valid));
          check_field("status_code", 32'(want.status_code), 32'(seen.status_code));
          check_field("store_valid", 32'(want.store_valid), 32'(seen.store_valid));
          check_field("store_address", 32'(want.store_address), 32'(seen.store_address));
          check_field("store_byte", 32'(want.store_byte), 32'(seen.store_byte));
          check_field("image_staged", 32'(want.image_staged), 32'(seen.image_staged));
        end
      end
      if (cfg_we) begin
        size_limit = cfg_wdata;
      end
      if (req.valid && req.ready) begin
        expected_q.push_back(apply_request(req.req_type, req.image_bytes, req.image_crc,
                                           req.chunk_offset, req.chunk_length,
                                           req.data_byte));
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the image transfer receiver. Drives directed corner requests,
// then phases of random transfers and stray requests under several size limits with
// random gaps on both channels and long response back-pressure; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
  import itr_pkg::*;
  import itr_tb_pkg::*;

  localparam int MAX_IMG      = 48;
  localparam int TARGET_ITEMS = 1625;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int unsigned       errors;
  int unsigned       pending;
  int unsigned       items;
  int unsigned       long_holds;
  bit                burst;
  logic [7:0]        img_data [0:MAX_IMG-1];

  itr_req_if #(.SIZE_BITS(SIZE_W)) req_ch ();
  itr_rsp_if #(.SIZE_BITS(SIZE_W)) rsp_ch ();

  image_transfer_receiver_crc16_unit #(.SIZE_BITS(SIZE_W)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  itr_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end else begin
      return $urandom_range(20, 50);
    end
  endfunction

  task automatic send_req(input logic [2:0] kind, input logic [SIZE_W-1:0] size,
                          input logic [15:0] crc, input logic [SIZE_W-1:0] off,
                          input logic [15:0] len, input logic [7:0] b);
    int unsigned n;
    if (!burst) begin
      n = gap_len();
      if (n != 0) begin
        req_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.image_bytes  <= size;
    req_ch.image_crc    <= crc;
    req_ch.chunk_offset <= off;
    req_ch.chunk_length <= len;
    req_ch.data_byte    <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    items++;
  endtask

  task automatic do_begin(input logic [SIZE_W-1:0] size, input logic [15:0] crc);
    send_req(REQ_BEGIN, size, crc, SIZE_W'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic do_chunk(input logic [SIZE_W-1:0] off, input logic [15:0] len);
    send_req(REQ_CHUNK, SIZE_W'($urandom), 16'($urandom), off, len, 8'($urandom));
  endtask

  task automatic do_data(input logic [7:0] b);
    send_req(REQ_DATA, SIZE_W'($urandom), 16'($urandom), SIZE_W'($urandom),
             16'($urandom), b);
  endtask

  task automatic do_commit();
    send_req(REQ_COMMIT, SIZE_W'($urandom), 16'($urandom), SIZE_W'($urandom),
             16'($urandom), 8'($urandom));
  endtask

  task automatic do_abort();
    send_req(REQ_ABORT, SIZE_W'($urandom), 16'($urandom), SIZE_W'($urandom),
             16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limit(input logic [SIZE_W-1:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // well-formed transfer with occasional repeats, partial chunks, bad headers
  task automatic run_image(input logic [SIZE_W-1:0] limit);
    int unsigned cap, size, cur, len, k, r, i;
    logic [15:0] crc;
    bit          done;
    cap  = (limit < MAX_IMG) ? limit : MAX_IMG;
    size = ($urandom_range(0, 9) == 0) ? cap : $urandom_range(1, cap);
    crc  = CRC_INIT;
    for (i = 0; i < size; i++) begin
      img_data[i] = 8'($urandom);
      crc = crc16_step(crc, img_data[i]);
    end
    if ($urandom_range(0, 99) < 15) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    do_begin(SIZE_W'(size), crc);
    cur  = 0;
    done = 1'b0;
    while (cur < size && !done) begin
      r = $urandom_range(0, 99);
      if (r < 6 && cur > 0) begin
        len = $urandom_range(1, 4);
        do_chunk(SIZE_W'($urandom_range(0, cur - 1)), 16'(len));
        repeat (len) do_data(8'($urandom));
      end else if (r < 12 && size - cur >= 2) begin
        len = $urandom_range(2, (size - cur > 16) ? 16 : size - cur);
        k   = $urandom_range(1, len - 1);
        do_chunk(SIZE_W'(cur), 16'(len));
        for (i = 0; i < k; i++) do_data(img_data[cur + i]);
        cur = cur + k;
      end else if (r < 17) begin
        case ($urandom_range(0, 2))
          0:       do_chunk(SIZE_W'(cur + $urandom_range(1, 300)), 16'($urandom_range(1, 16)));
          1:       do_chunk(SIZE_W'(cur), 16'd0);
          default: do_chunk(SIZE_W'(cur), 16'(size - cur + $urandom_range(1, 1000)));
        endcase
      end else if (r < 20) begin
        do_data(8'($urandom));
      end else if (r < 22) begin
        done = 1'b1;
      end else begin
        len = $urandom_range(1, (size - cur > 16) ? 16 : size - cur);
        do_chunk(SIZE_W'(cur), 16'(len));
        for (i = 0; i < len; i++) do_data(img_data[cur + i]);
        cur = cur + len;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 85) begin
      do_commit();
    end else if (r < 93) begin
      do_abort();
    end
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1) != 0) begin
        do_chunk(SIZE_W'(0), 16'd1);
      end else begin
        do_commit();
      end
    end
  endtask

  task automatic run_directed();
    logic [15:0] crc;
    crc = crc16_step(crc16_step(crc16_step(CRC_INIT, 8'h00), 8'hFF), 8'hA5);
    do_commit();
    do_chunk(SIZE_W'(0), 16'd1);
    do_data(8'h5A);
    send_req(REQ_RSVD_FIRST, '1, '1, '1, '1, '1);
    send_req(REQ_RSVD_LAST, '0, '0, '0, '0, '0);
    do_begin(SIZE_W'(0), 16'h1234);
    do_begin(SIZE_W'(MAX_IMAGE_RESET + 1), 16'h1234);
    do_begin('1, 16'hFFFF);
    do_begin(SIZE_W'(MAX_IMAGE_RESET), 16'h0000);
    do_begin(SIZE_W'(3), crc);
    do_chunk(SIZE_W'(1), 16'd1);
    do_chunk(SIZE_W'(0), 16'd0);
    do_chunk(SIZE_W'(0), 16'hFFFF);
    do_chunk(SIZE_W'(0), 16'd3);
    do_data(8'h00);
    do_data(8'hFF);
    do_commit();
    do_chunk(SIZE_W'(2), 16'd1);
    do_data(8'hA5);
    do_data(8'h3C);
    do_chunk(SIZE_W'(0), 16'd1);
    do_data(8'h77);
    do_commit();
    do_begin(SIZE_W'(0), 16'h0000);
    do_chunk(SIZE_W'(0), 16'd1);
    do_abort();
    set_limit('0);
    do_begin(SIZE_W'(1), 16'h0000);
    set_limit(SIZE_W'(1));
    do_begin(SIZE_W'(1), ~crc16_step(CRC_INIT, 8'h81));
    do_chunk(SIZE_W'(0), 16'd1);
    do_data(8'h81);
    do_commit();
  endtask

  // response side: random stalls plus two long hold-offs while requests flow
  initial begin : sink_side
    int unsigned run;
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    long_holds   = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
      repeat (run) @(negedge clk);
      stall = gap_len();
      if (long_holds < 2 && items >= 400 + long_holds * 700 && req_ch.valid) begin
        stall = 400;
        long_holds++;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    int unsigned       phase;
    int unsigned       phase_end;
    int unsigned       pick;
    int unsigned       guard;
    logic [SIZE_W-1:0] lim;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_BEGIN;
    req_ch.image_bytes  = '0;
    req_ch.image_crc    = '0;
    req_ch.chunk_offset = '0;
    req_ch.chunk_length = '0;
    req_ch.data_byte    = '0;
    items               = 0;
    burst               = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    phase = 0;
    while (items < TARGET_ITEMS) begin
      case (phase % 5)
        0:       lim = '1;
        1:       lim = SIZE_W'(1);
        2:       lim = SIZE_W'($urandom_range(2, 64));
        3:       lim = SIZE_W'(MAX_IMAGE_RESET);
        default: lim = SIZE_W'($urandom_range(1, 32'hFFFFFF));
      endcase
      set_limit(lim);
      phase_end = items + 320;
      while (items < phase_end && items < TARGET_ITEMS) begin
        burst = ($urandom_range(0, 7) == 0);
        pick  = $urandom_range(0, 99);
        if (pick < 80) begin
          run_image(lim);
        end else if (pick < 92) begin
          send_req(3'($urandom_range(0, 7)), SIZE_W'($urandom), 16'($urandom),
                   SIZE_W'($urandom), 16'($urandom), 8'($urandom));
        end else begin
          do_begin(SIZE_W'($urandom_range(1000, 32'hFFFFFF)), 16'($urandom));
          do_chunk(SIZE_W'(0), 16'($urandom_range(1, 16'hFFFF)));
          repeat ($urandom_range(0, 5)) do_data(8'($urandom));
          if ($urandom_range(0, 1) != 0) begin
            do_abort();
          end
        end
      end
      phase++;
    end
    burst = 1'b0;

    req_ch.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending != 0) begin
        $display("%0t: %0d responses never arrived", $time, pending);
      end
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("%0t: run did not complete", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/itr_pkg.sv
sv/itr_if.sv
sv/itr_front.sv
sv/itr_queue.sv
sv/itr_back.sv
sv/image_transfer_receiver_crc16_unit.sv
bench/itr_tb_pkg.sv
bench/itr_checker.sv
bench/tb_top.sv
